>>> src/lcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell ADC sampler package
// Shared transaction types, register indexes and constants for the sampler.
// ----------------------------------------------------------------------------
package lcas_pkg;

  // Width of one conversion result and of the running sum.
  localparam int DATA_BITS = 24;
  localparam int SUM_BITS  = 32;
  localparam int PULSE_BITS = 5;

  // Clock pulses per read for each gain and channel selection.
  localparam logic [PULSE_BITS-1:0] PULSES_A128 = PULSE_BITS'(25);
  localparam logic [PULSE_BITS-1:0] PULSES_B32  = PULSE_BITS'(26);
  localparam logic [PULSE_BITS-1:0] PULSES_A64  = PULSE_BITS'(27);

  // Gain selection codes.
  localparam logic [1:0] GAIN_A128 = 2'd0;
  localparam logic [1:0] GAIN_B32  = 2'd1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_CHANNEL   = 3'd0,
    CFG_INTERVAL       = 3'd1,
    CFG_SAMPLE_COUNT   = 3'd2,
    CFG_HALF_PERIOD    = 3'd3,
    CFG_SETTLE         = 3'd4,
    CFG_SLEEP_HOLD     = 3'd5,
    CFG_READY_TIMEOUT  = 3'd6,
    CFG_SLEEP_BETWEEN  = 3'd7
  } cfg_idx_t;

  // One timebase tick worth of input.
  typedef struct packed {
    logic dout_level;
    logic clear_new;
  } in_item_t;

  // Sampler status after one tick.
  typedef struct packed {
    logic                        sck_level;
    logic signed [SUM_BITS-1:0]  sample_sum;
    logic signed [DATA_BITS-1:0] last_sample;
    logic                        data_valid;
    logic                        new_data;
    logic                        sleeping;
  } out_item_t;

  // Total clock pulses for a read; every other selector code behaves like 64.
  function automatic logic [PULSE_BITS-1:0] pulse_total(input logic [1:0] gain);
    logic [PULSE_BITS-1:0] total;
    case (gain)
      GAIN_A128: total = PULSES_A128;
      GAIN_B32:  total = PULSES_B32;
      default:   total = PULSES_A64;
    endcase
    return total;
  endfunction

endpackage

>>> src/load_cell_adc_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load cell ADC sampler
// Drives the serial clock of a load-cell converter, reads and sums batches of
// 24-bit conversions, and reports clock level, sum and status per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_* is one timebase tick carrying the sampled
//   converter data pin and a clear request for the new-data flag. Every
//   accepted tick produces exactly one output transaction on out_* with the
//   clock pin level and the status after that tick.
//   The sequencer update is a single pass of logic between the state
//   registers and the output register. One tick can be accepted every cycle
//   while in_stall is low; each result is registered into the output
//   register, or into the one skid entry while the output register is full,
//   so a tick is still accepted while an earlier result waits. in_stall
//   rises only once both entries are full, i.e. after the receiver has stalled
//   with a second result pending; ticks then wait until out_stall drops.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
//   and take effect on the next tick; write them only while idle.
//   Reset (rst_n low, synchronous) loads the default register values, puts
//   the sequencer in the interval wait with the converter marked asleep
//   (clock pin high) and empties the output buffer.
// ----------------------------------------------------------------------------
module load_cell_adc_sampler (
  input  logic               clk,
  input  logic               rst_n,
  // Tick input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  lcas_pkg::in_item_t in_data,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output lcas_pkg::out_item_t out_data,
  // Configuration write port
  input  logic               cfg_we,
  input  lcas_pkg::cfg_idx_t cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import lcas_pkg::*;

  // Sequencer phases.
  typedef enum logic [5:0] {
    PH_WAIT  = 6'b000001,
    PH_WAKE  = 6'b000010,
    PH_READY = 6'b000100,
    PH_HIGH  = 6'b001000,
    PH_LOW   = 6'b010000,
    PH_SLEEP = 6'b100000
  } phase_t;

  // Configuration registers.
  logic [1:0]  gain_channel_r;
  logic [31:0] interval_ticks_r;
  logic [7:0]  sample_count_r;
  logic [7:0]  half_period_ticks_r;
  logic [31:0] settle_ticks_r;
  logic [15:0] sleep_hold_ticks_r;
  logic [31:0] ready_timeout_ticks_r;
  logic        sleep_between_r;

  // Sequencer state.
  phase_t                phase_r, phase_nxt;
  logic [31:0]           tick_count_r, tick_count_nxt;
  logic [PULSE_BITS-1:0] pulses_left_r, pulses_left_nxt;
  logic [DATA_BITS-1:0]  shift_bits_r, shift_bits_nxt;
  logic [DATA_BITS-1:0]  latest_value_r, latest_value_nxt;
  logic [SUM_BITS-1:0]   running_sum_r, running_sum_nxt;
  logic [7:0]            samples_left_r, samples_left_nxt;
  logic                  valid_flag_r, valid_flag_nxt;
  logic                  new_flag_r, new_flag_nxt;
  logic                  sleep_flag_r, sleep_flag_nxt;

  // Output buffer.
  out_item_t out_r, skid_r, result;
  logic      out_valid_r, skid_valid_r;

  // Helpers.
  logic                  in_accept;
  logic                  out_take;
  logic [31:0]           limit_raw;
  logic [31:0]           limit;
  logic [31:0]           tick_inc;
  logic                  tick_hit;
  logic [PULSE_BITS-1:0] total_pulses;
  logic [PULSE_BITS-1:0] extra_pulses;
  logic [7:0]            samples_dec;
  logic [DATA_BITS-1:0]  sum_source;
  logic [SUM_BITS-1:0]   sum_addend;
  logic                  sck_nxt;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_channel_r        <= GAIN_A128;
      interval_ticks_r      <= 32'd100000;
      sample_count_r        <= 8'd4;
      half_period_ticks_r   <= 8'd1;
      settle_ticks_r        <= 32'd400000;
      sleep_hold_ticks_r    <= 16'd80;
      ready_timeout_ticks_r <= 32'd200000;
      sleep_between_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GAIN_CHANNEL:  gain_channel_r        <= cfg_wdata[1:0];
        CFG_INTERVAL:      interval_ticks_r      <= cfg_wdata;
        CFG_SAMPLE_COUNT:  sample_count_r        <= cfg_wdata[7:0];
        CFG_HALF_PERIOD:   half_period_ticks_r   <= cfg_wdata[7:0];
        CFG_SETTLE:        settle_ticks_r        <= cfg_wdata;
        CFG_SLEEP_HOLD:    sleep_hold_ticks_r    <= cfg_wdata[15:0];
        CFG_READY_TIMEOUT: ready_timeout_ticks_r <= cfg_wdata;
        CFG_SLEEP_BETWEEN: sleep_between_r       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Duration of the current phase; a zero duration counts as one tick.
  always_comb begin
    case (phase_r)
      PH_WAKE:  limit_raw = settle_ticks_r;
      PH_READY: limit_raw = ready_timeout_ticks_r;
      PH_HIGH:  limit_raw = {24'd0, half_period_ticks_r};
      PH_LOW:   limit_raw = {24'd0, half_period_ticks_r};
      PH_SLEEP: limit_raw = {16'd0, sleep_hold_ticks_r};
      default:  limit_raw = interval_ticks_r;
    endcase
  end

  assign limit    = (limit_raw == 32'd0) ? 32'd1 : limit_raw;
  assign tick_inc = tick_count_r + 32'd1;
  assign tick_hit = (tick_inc >= limit);

  assign total_pulses = pulse_total(gain_channel_r);
  assign extra_pulses = total_pulses - PULSE_BITS'(DATA_BITS);
  assign samples_dec  = (samples_left_r != 8'd0) ? samples_left_r - 8'd1 : 8'd0;

  // The conversion added to the sum: a fresh one, or the stale one on timeout.
  assign sum_source = (phase_r == PH_LOW) ? shift_bits_r : latest_value_r;
  assign sum_addend = {{(SUM_BITS-DATA_BITS){sum_source[DATA_BITS-1]}}, sum_source};

  // Sequencer next state for one tick.
  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    pulses_left_nxt  = pulses_left_r;
    shift_bits_nxt   = shift_bits_r;
    latest_value_nxt = latest_value_r;
    running_sum_nxt  = running_sum_r;
    samples_left_nxt = samples_left_r;
    valid_flag_nxt   = valid_flag_r;
    new_flag_nxt     = new_flag_r && !in_data.clear_new;
    sleep_flag_nxt   = sleep_flag_r;

    case (phase_r)
      PH_WAKE: begin
        tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
        if (tick_hit) begin
          sleep_flag_nxt   = 1'b0;
          running_sum_nxt  = '0;
          samples_left_nxt = (sample_count_r != 8'd0) ? sample_count_r : 8'd1;
          phase_nxt        = PH_READY;
        end
      end
      PH_READY: begin
        if (!in_data.dout_level) begin
          pulses_left_nxt = total_pulses;
          shift_bits_nxt  = '0;
          tick_count_nxt  = 32'd0;
          phase_nxt       = PH_HIGH;
        end else begin
          tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
          if (tick_hit) begin
            // Timeout: the previous conversion is summed again.
            running_sum_nxt  = running_sum_r + sum_addend;
            samples_left_nxt = samples_dec;
            if (samples_dec == 8'd0) begin
              new_flag_nxt = new_flag_nxt || valid_flag_r;
              phase_nxt    = sleep_between_r ? PH_SLEEP : PH_WAIT;
            end else begin
              phase_nxt = PH_READY;
            end
          end
        end
      end
      PH_HIGH: begin
        tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
        if (tick_hit) begin
          // Only the data bits are shifted in; the trailing gain pulses are not.
          if (pulses_left_r > extra_pulses) begin
            shift_bits_nxt = {shift_bits_r[DATA_BITS-2:0], in_data.dout_level};
          end
          if (pulses_left_r != '0) begin
            pulses_left_nxt = pulses_left_r - PULSE_BITS'(1);
          end
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
        if (tick_hit) begin
          if (pulses_left_r == '0) begin
            latest_value_nxt = shift_bits_r;
            valid_flag_nxt   = 1'b1;
            running_sum_nxt  = running_sum_r + sum_addend;
            samples_left_nxt = samples_dec;
            if (samples_dec == 8'd0) begin
              new_flag_nxt = 1'b1;
              phase_nxt    = sleep_between_r ? PH_SLEEP : PH_WAIT;
            end else begin
              phase_nxt = PH_READY;
            end
          end else begin
            phase_nxt = PH_HIGH;
          end
        end
      end
      PH_SLEEP: begin
        tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
        if (tick_hit) begin
          sleep_flag_nxt = 1'b1;
          phase_nxt      = PH_WAIT;
        end
      end
      default: begin
        // Interval wait, also taken for any stray phase code.
        phase_nxt      = PH_WAIT;
        tick_count_nxt = tick_hit ? 32'd0 : tick_inc;
        if (tick_hit) begin
          valid_flag_nxt = 1'b0;
          if (sleep_flag_r) begin
            phase_nxt = PH_WAKE;
          end else begin
            running_sum_nxt  = '0;
            samples_left_nxt = (sample_count_r != 8'd0) ? sample_count_r : 8'd1;
            phase_nxt        = PH_READY;
          end
        end
      end
    endcase
  end

  // Clock pin level and result transaction built from the next state.
  always_comb begin
    case (phase_nxt)
      PH_HIGH:  sck_nxt = 1'b1;
      PH_SLEEP: sck_nxt = 1'b1;
      PH_WAIT:  sck_nxt = sleep_flag_nxt;
      default:  sck_nxt = 1'b0;
    endcase
    result.sck_level   = sck_nxt;
    result.sample_sum  = running_sum_nxt;
    result.last_sample = latest_value_nxt;
    result.data_valid  = valid_flag_nxt;
    result.new_data    = new_flag_nxt;
    result.sleeping    = sleep_flag_nxt;
  end

  // Sequencer state registers, advanced once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      tick_count_r   <= '0;
      pulses_left_r  <= '0;
      shift_bits_r   <= '0;
      latest_value_r <= '0;
      running_sum_r  <= '0;
      samples_left_r <= '0;
      valid_flag_r   <= 1'b0;
      new_flag_r     <= 1'b0;
      sleep_flag_r   <= 1'b1;
    end else if (in_accept) begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      pulses_left_r  <= pulses_left_nxt;
      shift_bits_r   <= shift_bits_nxt;
      latest_value_r <= latest_value_nxt;
      running_sum_r  <= running_sum_nxt;
      samples_left_r <= samples_left_nxt;
      valid_flag_r   <= valid_flag_nxt;
      new_flag_r     <= new_flag_nxt;
      sleep_flag_r   <= sleep_flag_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    if (out_take && skid_valid_r) begin
      out_r <= skid_r;
    end else if (in_accept && (out_take || !out_valid_r)) begin
      out_r <= result;
    end
    if (in_accept && out_valid_r && !out_take) begin
      skid_r <= result;
    end
  end

  // The skid entry is only used behind a full output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a transaction while the output register is empty");

  // A data-ready tick in the ready phase starts a read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_READY && !in_data.dout_level) |=> (phase_r == PH_HIGH))
    else $error("data ready did not start a read");

  // Inside a batch at least one sample is still outstanding.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY || phase_r == PH_HIGH || phase_r == PH_LOW)
      |-> (samples_left_r != 8'd0))
    else $error("batch phase with no samples left");

  // The pulse counter never exceeds the longest read.
  assert property (@(posedge clk) disable iff (!rst_n)
    pulses_left_r <= PULSES_A64)
    else $error("pulse counter out of range");

endmodule
